// ===== rtl/scrc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scrc_pkg - sensor command/report controller package
// Request types, command codes, register indexes and keyword tables.
// ----------------------------------------------------------------------------
package scrc_pkg;

  localparam int unsigned KEYWORDS   = 7;
  localparam int unsigned NUM_START  = 7;
  localparam int unsigned LINE_LEN_W = 8;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_0     = 8'd48;
  localparam logic [7:0] CHAR_9     = 8'd57;

  localparam logic [CFG_IDX_W-1:0] REG_START_PERIOD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_CELSIUS = 1'd1;

  typedef enum logic [2:0] {
    CMD_UNKNOWN = 3'd0,
    CMD_SCALE_F = 3'd1,
    CMD_SCALE_C = 3'd2,
    CMD_PERIOD  = 3'd3,
    CMD_STOP    = 3'd4,
    CMD_START   = 3'd5,
    CMD_LOG     = 3'd6,
    CMD_OFF     = 3'd7
  } cmd_code_t;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_TICK   = 1'b1;
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_CMD    = 1'b1;

  typedef struct packed {
    logic                item_kind;
    logic [7:0]          byte_value;
    logic [SAMPLE_W-1:0] sensor_sample;
  } in_item_t;

  typedef struct packed {
    logic                result_kind;
    logic [2:0]          command_code;
    logic [SAMPLE_W-1:0] report_sample;
    logic                unit_celsius;
    logic [PERIOD_W-1:0] period_now;
    logic                halted_flag;
  } out_item_t;

  typedef struct packed {
    cmd_code_t           code;
    logic [PERIOD_W-1:0] period;
  } cmd_done_t;

  // keyword text, left aligned, first character in the top byte
  function automatic logic [55:0] kw_text(input int unsigned k);
    logic [55:0] t;
    case (k)
      0:       t = "SCALE=F";
      1:       t = "SCALE=C";
      2:       t = "PERIOD=";
      3:       t = {"STOP", 24'h0};
      4:       t = {"START", 16'h0};
      5:       t = {"LOG ", 24'h0};
      6:       t = {"OFF", 32'h0};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] kw_char(input int unsigned k, input logic [2:0] pos);
    logic [55:0] t;
    t = kw_text(k);
    return t[55 - 8 * int'(pos) -: 8];
  endfunction

  function automatic logic [LINE_LEN_W-1:0] kw_len(input int unsigned k);
    logic [LINE_LEN_W-1:0] n;
    case (k)
      0, 1, 2: n = 8'd7;
      3, 5:    n = 8'd4;
      4:       n = 8'd5;
      6:       n = 8'd3;
      default: n = 8'd0;
    endcase
    return n;
  endfunction

  function automatic logic kw_prefix(input int unsigned k);
    return (k == 2) || (k == 5);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/scrc_cmd_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scrc_cmd_parser - command line matcher
// Per-keyword prefix flags, line length and PERIOD= number parse; decodes the
// command at line end.
// ----------------------------------------------------------------------------
module scrc_cmd_parser #(
  parameter int unsigned LINE_MAX = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 take_en,
  input  wire logic                 end_en,
  input  wire logic [7:0]           byte_value,
  output scrc_pkg::cmd_done_t       done
);

  localparam logic [scrc_pkg::LINE_LEN_W-1:0] LINE_MAX_C =
    scrc_pkg::LINE_LEN_W'(LINE_MAX);
  localparam logic [scrc_pkg::LINE_LEN_W-1:0] NUM_START_C =
    scrc_pkg::LINE_LEN_W'(scrc_pkg::NUM_START);

  typedef enum logic [1:0] {
    NUM_IDLE   = 2'd0,
    NUM_DIGITS = 2'd1,
    NUM_DONE   = 2'd2
  } num_phase_t;

  logic [scrc_pkg::KEYWORDS-1:0]   match_r, match_nxt;
  logic [scrc_pkg::LINE_LEN_W-1:0] len_r, len_nxt;
  num_phase_t                      phase_r, phase_nxt;
  logic                            neg_r, neg_nxt;
  logic [scrc_pkg::PERIOD_W-1:0]   value_r, value_nxt;

  logic       is_digit;
  logic [3:0] digit;
  logic [19:0] value_ext;

  assign is_digit  = (byte_value >= scrc_pkg::CHAR_0) && (byte_value <= scrc_pkg::CHAR_9);
  assign digit     = 4'(byte_value - scrc_pkg::CHAR_0);
  assign value_ext = {1'b0, value_r, 3'b000} + {3'b000, value_r, 1'b0} + {16'h0, digit};

  always_comb begin
    match_nxt = match_r;
    len_nxt   = len_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    value_nxt = value_r;
    if (end_en) begin
      match_nxt = '1;
      len_nxt   = '0;
      phase_nxt = NUM_IDLE;
      neg_nxt   = 1'b0;
      value_nxt = '0;
    end else if (take_en && (len_r < LINE_MAX_C)) begin
      for (int unsigned k = 0; k < scrc_pkg::KEYWORDS; k++) begin
        if ((len_r < scrc_pkg::kw_len(k)) &&
            (byte_value != scrc_pkg::kw_char(k, len_r[2:0]))) begin
          match_nxt[k] = 1'b0;
        end
      end
      if (len_r >= NUM_START_C) begin
        case (phase_r)
          NUM_IDLE: begin
            if (byte_value inside {scrc_pkg::CHAR_SPACE,
                                   [scrc_pkg::CHAR_TAB:scrc_pkg::CHAR_CR]}) begin
              phase_nxt = NUM_IDLE;
            end else if (byte_value == scrc_pkg::CHAR_PLUS) begin
              phase_nxt = NUM_DIGITS;
            end else if (byte_value == scrc_pkg::CHAR_MINUS) begin
              neg_nxt   = 1'b1;
              phase_nxt = NUM_DIGITS;
            end else if (is_digit) begin
              value_nxt = {12'h0, digit};
              phase_nxt = NUM_DIGITS;
            end else begin
              phase_nxt = NUM_DONE;
            end
          end
          NUM_DIGITS: begin
            if (is_digit) begin
              value_nxt = (value_ext > 20'd65535) ? 16'hFFFF : value_ext[15:0];
            end else begin
              phase_nxt = NUM_DONE;
            end
          end
          default: ;
        endcase
      end
      len_nxt = len_r + 8'd1;
    end
  end

  // first matching keyword wins
  always_comb begin
    logic ok;
    done.code = scrc_pkg::CMD_UNKNOWN;
    for (int k = scrc_pkg::KEYWORDS - 1; k >= 0; k--) begin
      ok = scrc_pkg::kw_prefix(k) ? (len_r >= scrc_pkg::kw_len(k))
                                  : (len_r == scrc_pkg::kw_len(k));
      if (match_r[k] && ok) begin
        done.code = scrc_pkg::cmd_code_t'(3'(k + 1));
      end
    end
    done.period = (neg_r || (value_r == '0)) ? '0 : value_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= '1;
      len_r   <= '0;
      phase_r <= NUM_IDLE;
      neg_r   <= 1'b0;
      value_r <= '0;
    end else begin
      match_r <= match_nxt;
      len_r   <= len_nxt;
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      value_r <= value_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sensor_command_report_controller.sv =====
`default_nettype none
// A request passes the input register; its result is then written to the result register.
// Throughput: one request per cycle unless a stalled result blocks the input; the state
// update per request (command matcher, tick counter) sets this figure.
// A stalled result only blocks input when the next request also produces one.
// Reset (synchronous, active low) clears the line state, loads period 1 and
// Fahrenheit, clears the stop/halt flags and empties both pipeline registers.
// ----------------------------------------------------------------------------
// sensor_command_report_controller - top level
// Input register, command/tick processing and result register.
// ----------------------------------------------------------------------------
module sensor_command_report_controller #(
  parameter int unsigned LINE_MAX = 128
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire scrc_pkg::in_item_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output scrc_pkg::out_item_t                     out_data,
  input  wire logic                               cfg_we,
  input  wire logic [scrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [scrc_pkg::PERIOD_W-1:0]      cfg_data
);

  logic                          s1_valid_r;
  scrc_pkg::in_item_t            s1_data_r;
  logic                          out_valid_r;
  scrc_pkg::out_item_t           out_data_r, res_data;
  logic                          res_valid, advance;

  logic [scrc_pkg::PERIOD_W-1:0] period_r, period_nxt;
  logic                          unit_r, unit_nxt;
  logic                          stopped_r, stopped_nxt;
  logic [scrc_pkg::PERIOD_W-1:0] secs_r, secs_nxt, secs_inc;
  logic                          halted_r, halted_nxt;

  logic                          is_byte, is_lf, take_en, end_en;
  scrc_pkg::cmd_done_t           done;

  assign is_byte = s1_valid_r && !halted_r && (s1_data_r.item_kind == scrc_pkg::KIND_BYTE);
  assign is_lf   = (s1_data_r.byte_value == scrc_pkg::CHAR_LF);
  assign take_en = advance && is_byte && !is_lf;
  assign end_en  = advance && is_byte && is_lf;
  assign secs_inc = secs_r + 16'd1;

  scrc_cmd_parser #(
    .LINE_MAX (LINE_MAX)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .take_en    (take_en),
    .end_en     (end_en),
    .byte_value (s1_data_r.byte_value),
    .done       (done)
  );

  always_comb begin
    period_nxt  = period_r;
    unit_nxt    = unit_r;
    stopped_nxt = stopped_r;
    secs_nxt    = secs_r;
    halted_nxt  = halted_r;
    res_valid   = 1'b0;
    if (s1_valid_r && !halted_r) begin
      if (s1_data_r.item_kind == scrc_pkg::KIND_BYTE) begin
        if (is_lf) begin
          res_valid = 1'b1;
          case (done.code)
            scrc_pkg::CMD_SCALE_F: unit_nxt    = 1'b0;
            scrc_pkg::CMD_SCALE_C: unit_nxt    = 1'b1;
            scrc_pkg::CMD_PERIOD:  period_nxt  = done.period;
            scrc_pkg::CMD_STOP:    stopped_nxt = 1'b1;
            scrc_pkg::CMD_START:   stopped_nxt = 1'b0;
            scrc_pkg::CMD_OFF:     halted_nxt  = 1'b1;
            default: ;
          endcase
        end
      end else begin
        secs_nxt = secs_inc;
        if (secs_inc >= period_r) begin
          secs_nxt  = '0;
          res_valid = !stopped_r;
        end
      end
    end
    res_data.result_kind   = is_lf && (s1_data_r.item_kind == scrc_pkg::KIND_BYTE)
                             ? scrc_pkg::KIND_CMD : scrc_pkg::KIND_REPORT;
    res_data.command_code  = (res_data.result_kind == scrc_pkg::KIND_CMD) ? done.code
                                                                          : scrc_pkg::CMD_UNKNOWN;
    res_data.report_sample = (res_data.result_kind == scrc_pkg::KIND_CMD) ? '0
                                                                          : s1_data_r.sensor_sample;
    res_data.unit_celsius  = unit_nxt;
    res_data.period_now    = period_nxt;
    res_data.halted_flag   = halted_nxt;
  end

  assign advance  = s1_valid_r && (!res_valid || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      period_r    <= 16'd1;
      unit_r      <= 1'b0;
      stopped_r   <= 1'b0;
      secs_r      <= '0;
      halted_r    <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        period_r  <= period_nxt;
        unit_r    <= unit_nxt;
        stopped_r <= stopped_nxt;
        secs_r    <= secs_nxt;
        halted_r  <= halted_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          scrc_pkg::REG_START_PERIOD:  period_r <= cfg_data;
          scrc_pkg::REG_START_CELSIUS: unit_r   <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  // once halted, no new result is produced
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r && !out_valid_r |=> !out_valid_r)
    else $error("result produced while halted");

  // a result flagged halted implies the halt state is set
  a_halt_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.halted_flag |-> halted_r)
    else $error("halted flag without halt state");

  // a blocked input stage holds its request
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_data_r))
    else $error("input stage lost a request");
`endif

endmodule
`default_nettype wire

// ===== tb/scrc_report_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scrc_report_checker - result checker for the sensor command/report controller
// Follows register writes and accepted requests, predicts the command and
// temperature results and compares every accepted result, in order, field by
// field. Hands the failure count and the number of awaited results to the top.
// ----------------------------------------------------------------------------
module scrc_report_checker #(
  parameter int unsigned LINE_MAX = 128
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire logic                               in_ready,
  input  wire scrc_pkg::in_item_t                 in_data,
  input  wire logic                               out_valid,
  input  wire logic                               out_ready,
  input  wire scrc_pkg::out_item_t                out_data,
  input  wire logic                               cfg_we,
  input  wire logic [scrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [scrc_pkg::PERIOD_W-1:0]      cfg_data,
  output int                                      failures,
  output int                                      pending,
  output int                                      requests_seen,
  output int                                      reports_seen,
  output int                                      commands_seen
);
  import scrc_pkg::*;

  localparam int MAX_PRINTED = 40;

  typedef enum logic [1:0] {
    NUM_LEAD   = 2'd0,
    NUM_DIGITS = 2'd1,
    NUM_DONE   = 2'd2
  } num_phase_t;

  // line matcher, bit k tracks command code k
  logic [7:1]          kw_alive;
  logic [7:0]          line_len;
  num_phase_t          num_phase;
  logic                num_neg;
  logic [PERIOD_W-1:0] num_val;
  // controller state
  logic [PERIOD_W-1:0] period;
  logic                celsius;
  logic                stopped;
  logic [15:0]         secs;
  logic                halted;

  out_item_t awaited_results [$];
  out_item_t want;
  int        fail_count;
  int        request_count;
  int        report_count;
  int        command_count;

  function automatic string keyword_of(input cmd_code_t c);
    case (c)
      CMD_SCALE_F: return "SCALE=F";
      CMD_SCALE_C: return "SCALE=C";
      CMD_PERIOD:  return "PERIOD=";
      CMD_STOP:    return "STOP";
      CMD_START:   return "START";
      CMD_LOG:     return "LOG ";
      CMD_OFF:     return "OFF";
      default:     return "";
    endcase
  endfunction

  function automatic out_item_t make_result(input logic kind, input cmd_code_t code,
                                            input logic [SAMPLE_W-1:0] sample);
    out_item_t r;
    r.result_kind   = kind;
    r.command_code  = code;
    r.report_sample = sample;
    r.unit_celsius  = celsius;
    r.period_now    = period;
    r.halted_flag   = halted;
    return r;
  endfunction

  task automatic clear_line();
    kw_alive  = '1;
    line_len  = '0;
    num_phase = NUM_LEAD;
    num_neg   = 1'b0;
    num_val   = '0;
  endtask

  // atoi-style number after "PERIOD="
  task automatic parse_number_char(input logic [7:0] c);
    logic        is_digit;
    logic        is_space;
    logic [19:0] acc;
    is_digit = (c >= CHAR_0) && (c <= CHAR_9);
    is_space = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    case (num_phase)
      NUM_LEAD: begin
        if (c == CHAR_PLUS) begin
          num_phase = NUM_DIGITS;
        end else if (c == CHAR_MINUS) begin
          num_neg   = 1'b1;
          num_phase = NUM_DIGITS;
        end else if (is_digit) begin
          num_val   = PERIOD_W'(c - CHAR_0);
          num_phase = NUM_DIGITS;
        end else if (!is_space) begin
          num_phase = NUM_DONE;
        end
      end
      NUM_DIGITS: begin
        if (is_digit) begin
          acc     = 20'(num_val) * 20'd10 + 20'(c - CHAR_0);
          num_val = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
        end else begin
          num_phase = NUM_DONE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic take_line_char(input logic [7:0] c);
    string kw;
    if (line_len < LINE_MAX) begin
      for (int k = 1; k < 8; k++) begin
        kw = keyword_of(cmd_code_t'(k));
        if ((line_len < kw.len()) && (c != kw[line_len])) kw_alive[k] = 1'b0;
      end
      if (line_len >= NUM_START) parse_number_char(c);
      line_len = line_len + 8'd1;
    end
  endtask

  task automatic finish_line(output cmd_code_t hit);
    string kw;
    logic  len_ok;
    logic  found;
    hit   = CMD_UNKNOWN;
    found = 1'b0;
    for (int k = 1; k < 8; k++) begin
      kw = keyword_of(cmd_code_t'(k));
      if ((k == CMD_PERIOD) || (k == CMD_LOG)) len_ok = (line_len >= kw.len());
      else len_ok = (line_len == kw.len());
      if (!found && kw_alive[k] && len_ok) begin
        hit   = cmd_code_t'(k);
        found = 1'b1;
      end
    end
    case (hit)
      CMD_SCALE_F: celsius = 1'b0;
      CMD_SCALE_C: celsius = 1'b1;
      CMD_PERIOD:  period  = (num_neg || (num_val == '0)) ? '0 : num_val;
      CMD_STOP:    stopped = 1'b1;
      CMD_START:   stopped = 1'b0;
      CMD_OFF:     halted  = 1'b1;
      default: ;
    endcase
    clear_line();
  endtask

  task automatic apply_request(input in_item_t req);
    cmd_code_t code;
    if (!halted) begin
      if (req.item_kind == KIND_BYTE) begin
        if (req.byte_value == CHAR_LF) begin
          finish_line(code);
          awaited_results.push_back(make_result(KIND_CMD, code, '0));
        end else begin
          take_line_char(req.byte_value);
        end
      end else begin
        secs = secs + 16'd1;
        if (secs >= period) begin
          secs = '0;
          if (!stopped)
            awaited_results.push_back(make_result(KIND_REPORT, CMD_UNKNOWN, req.sensor_sample));
        end
      end
    end
  endtask

  task automatic compare_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
    if (exp_val != act_val) begin
      if (fail_count < MAX_PRINTED)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_line();
      period  = 16'd1;
      celsius = 1'b0;
      stopped = 1'b0;
      secs    = '0;
      halted  = 1'b0;
      awaited_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_START_PERIOD) period = cfg_data;
        else if (cfg_index == REG_START_CELSIUS) celsius = cfg_data[0];
      end
      if (out_valid && out_ready) begin
        if (out_data.result_kind == KIND_REPORT) report_count++;
        else command_count++;
        if (awaited_results.size() == 0) begin
          if (fail_count < MAX_PRINTED)
            $display("%0t: unexpected result: expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("result_kind", want.result_kind, out_data.result_kind);
          compare_field("command_code", want.command_code, out_data.command_code);
          compare_field("report_sample", want.report_sample, out_data.report_sample);
          compare_field("unit_celsius", want.unit_celsius, out_data.unit_celsius);
          compare_field("period_now", want.period_now, out_data.period_now);
          compare_field("halted_flag", want.halted_flag, out_data.halted_flag);
        end
      end
      if (in_valid && in_ready) begin
        request_count++;
        apply_request(in_data);
      end
    end
    failures      <= fail_count;
    pending       <= awaited_results.size();
    requests_seen <= request_count;
    reports_seen  <= report_count;
    commands_seen <= command_count;
  end

endmodule
`default_nettype wire

// ===== tb/sensor_command_report_controller_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_command_report_controller_tb - testbench top
// Drives command lines and sensor ticks through the request channel: a
// directed set of keywords, number forms and odd lines, then random lines
// under three sender/receiver pacing mixes with register changes in between,
// and OFF at the very end. The checker predicts and compares the results.
// ----------------------------------------------------------------------------
module sensor_command_report_controller_tb;
  import scrc_pkg::*;

  localparam int unsigned LINE_MAX       = 128;
  localparam int          IDLE_GAP       = 6;
  localparam int          WATCHDOG_LIMIT = 3000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PERIOD_W-1:0]  cfg_data;

  int failures;
  int pending;
  int requests_seen;
  int reports_seen;
  int commands_seen;

  int in_idle_pct;
  int out_stall_pct;
  int sent;
  int settings_written;
  int quiet_cycles;

  logic [7:0] line_buf [$];

  sensor_command_report_controller #(
    .LINE_MAX(LINE_MAX)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  scrc_report_checker #(
    .LINE_MAX(LINE_MAX)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .failures     (failures),
    .pending      (pending),
    .requests_seen(requests_seen),
    .reports_seen (reports_seen),
    .commands_seen(commands_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, quiet_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [7:0] rand_char();
    logic [7:0] b;
    b = 8'($urandom_range(254));
    if (b >= CHAR_LF) b = b + 8'd1;
    return b;
  endfunction

  task automatic send_item(input in_item_t req);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_tick(input logic [SAMPLE_W-1:0] sample);
    in_item_t req;
    req.item_kind     = KIND_TICK;
    req.byte_value    = 8'($urandom_range(255));
    req.sensor_sample = sample;
    send_item(req);
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t req;
    req.item_kind     = KIND_BYTE;
    req.byte_value    = b;
    req.sensor_sample = SAMPLE_W'($urandom_range(1023));
    send_item(req);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // line bytes with the odd tick in between, then the line end
  task automatic send_line();
    foreach (line_buf[i]) begin
      if ($urandom_range(24) == 0) send_tick(SAMPLE_W'($urandom_range(1023)));
      send_byte(line_buf[i]);
    end
    send_byte(CHAR_LF);
  endtask

  task automatic send_text(input string s);
    line_buf.delete();
    push_text(s);
    send_line();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic write_regs(input logic [PERIOD_W-1:0] start_period,
                            input logic start_celsius);
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_PERIOD;
    cfg_data  <= start_period;
    @(posedge clk);
    cfg_index <= REG_START_CELSIUS;
    cfg_data  <= {15'($urandom), start_celsius};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_written++;
  endtask

  function automatic string any_keyword();
    case ($urandom_range(6))
      0:       return "SCALE=F";
      1:       return "SCALE=C";
      2:       return "PERIOD=";
      3:       return "STOP";
      4:       return "START";
      5:       return "LOG ";
      default: return "OFF";
    endcase
  endfunction

  task automatic build_random_line();
    int pick;
    line_buf.delete();
    pick = $urandom_range(99);
    if (pick < 28) begin
      push_text("PERIOD=");
      repeat ($urandom_range(2))
        line_buf.push_back($urandom_range(1) ? CHAR_SPACE : 8'($urandom_range(9, 13)));
      case ($urandom_range(5))
        0:       line_buf.push_back(CHAR_PLUS);
        1:       line_buf.push_back(CHAR_MINUS);
        default: ;
      endcase
      if ($urandom_range(11) == 0) begin
        repeat ($urandom_range(4, 8)) line_buf.push_back(CHAR_0 + 8'($urandom_range(9)));
      end else if ($urandom_range(15) != 0) begin
        line_buf.push_back(CHAR_0 + 8'($urandom_range(4)));
      end
      if ($urandom_range(5) == 0) line_buf.push_back(rand_char());
    end else if (pick < 38) begin
      push_text($urandom_range(1) ? "SCALE=F" : "SCALE=C");
    end else if (pick < 44) begin
      push_text("STOP");
    end else if (pick < 54) begin
      push_text("START");
    end else if (pick < 60) begin
      push_text("LOG ");
      repeat ($urandom_range(6)) line_buf.push_back(rand_char());
    end else if (pick < 80) begin
      push_text(any_keyword());
      case ($urandom_range(3))
        0:       void'(line_buf.pop_back());
        1:       line_buf.push_back(rand_char());
        2:       line_buf[$urandom_range(line_buf.size() - 1)] = rand_char();
        default: line_buf.push_front(CHAR_SPACE);
      endcase
    end else if (pick < 97) begin
      repeat ($urandom_range(10)) line_buf.push_back(rand_char());
    end else begin
      case ($urandom_range(3))
        0:       push_text("PERIOD=3");
        1:       push_text("LOG ");
        2:       push_text("SCALE=C");
        default: ;
      endcase
      while (line_buf.size() < LINE_MAX - 3 + $urandom_range(12))
        line_buf.push_back(rand_char());
    end
    // OFF halts until reset, so it is kept for the end of the run
    if (line_buf.size() == 3 && line_buf[0] == "O" && line_buf[1] == "F" && line_buf[2] == "F")
      line_buf.push_front(CHAR_SPACE);
  endtask

  task automatic run_random(input int count);
    int target;
    target = sent + count;
    while (sent < target) begin
      repeat ($urandom_range(3)) send_tick(SAMPLE_W'($urandom_range(1023)));
      build_random_line();
      send_line();
    end
  endtask

  task automatic run_directed();
    send_text("");
    send_tick('0);
    send_tick('1);
    send_text("SCALE=C");
    send_text("SCALE=F");
    send_text("SCALE=Fx");
    send_text("PERIOD=-5");
    send_tick(SAMPLE_W'(341));
    send_text("PERIOD=\t+99999");
    send_text("PERIOD=");
    send_text("PERIOD=2");
    repeat (3) send_tick(SAMPLE_W'($urandom_range(1023)));
    send_text("STOP");
    repeat (2) send_tick(SAMPLE_W'($urandom_range(1023)));
    send_text("START");
    repeat (2) send_tick(SAMPLE_W'($urandom_range(1023)));
    send_text("LOG entry");
    line_buf.delete();
    line_buf.push_back(8'h00);
    push_text("STOP");
    send_line();
    line_buf.delete();
    line_buf.push_back(8'hFF);
    send_line();
    // over-long lines: digits saturate, exact keywords can no longer match
    line_buf.delete();
    push_text("PERIOD=7");
    repeat (LINE_MAX) line_buf.push_back(CHAR_9);
    send_line();
    line_buf.delete();
    push_text("STOP");
    repeat (LINE_MAX) line_buf.push_back("x");
    send_line();
    send_text("PERIOD=1");
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data          = '0;
    out_ready        = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_idle_pct      = 24;
    out_stall_pct    = 86;
    sent             = 0;
    settings_written = 0;
    quiet_cycles     = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    write_regs(16'd1, 1'b1);
    run_directed();
    run_random(400);
    wait_idle();

    in_idle_pct   = 86;
    out_stall_pct = 24;
    write_regs(16'hFFFF, 1'b0);
    run_random(400);
    wait_idle();

    in_idle_pct   = 0;
    out_stall_pct = 0;
    write_regs(16'($urandom_range(2, 9)), 1'b1);
    run_random(170);
    wait_idle();
    run_random(170);
    wait_idle();

    write_regs(16'd1, 1'b0);
    send_tick(SAMPLE_W'($urandom_range(1023)));
    send_text("OFF");
    send_tick(SAMPLE_W'($urandom_range(1023)));
    send_text("START");
    wait_idle();

    $display("Run covered %0d requests, %0d temperature reports and %0d command results,",
             requests_seen, reports_seen, commands_seen);
    $display("over three pacing mixes and %0d register settings, ending halted by OFF.",
             settings_written);
    if (failures == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
